/* rtl/htwd_pkg.sv */
`default_nettype none
package htwd_pkg;

  localparam int NODE_COUNT_DEF = 512;
  localparam int BITS_PER_BYTE  = 8;
  localparam int IDX_W          = 9;
  localparam int SYM_W          = 8;
  localparam int CNT_W          = 4;
  localparam int IN_TDATA_W     = 56;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } walk_state_t;

  // one table node, packed as the load item delivers it
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             leaf;
    logic             rp;
    logic             lp;
    logic [IDX_W-1:0] right;
    logic [IDX_W-1:0] left;
  } node_t;

  typedef struct packed {
    cmd_t                     command;
    logic [IDX_W-1:0]         node_index;
    node_t                    node;
    logic [BITS_PER_BYTE-1:0] data_byte;
    logic [CNT_W-1:0]         valid_bits;
    logic                     eos;
  } item_t;

  typedef struct packed {
    logic             err;
    logic [SYM_W-1:0] sym;
  } res_t;

  typedef struct packed {
    logic valid;
    logic last;
    res_t res;
  } push_t;

endpackage
`default_nettype wire

/* rtl/htwd_node_mem.sv */
`default_nettype none
module htwd_node_mem import htwd_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int AW         = $clog2(NODE_COUNT)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire node_t         wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output node_t              rdata
);

  node_t mem_r [NODE_COUNT];
  node_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // read data holds while the walk is stalled
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/htwd_walker.sv */
`default_nettype none
module htwd_walker import htwd_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int AW         = $clog2(NODE_COUNT)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire item_t         item,
  input  wire logic          item_valid,
  output logic               item_ready,
  output push_t              push,
  input  wire logic          push_ready,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output node_t              mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  wire node_t         mem_rdata
);

  walk_state_t              state_r, state_nxt;
  logic [BITS_PER_BYTE-1:0] bits_r, bits_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     eos_r, eos_nxt;
  logic                     pend_r, pend_nxt;
  logic [IDX_W-1:0]         pend_idx_r, pend_idx_nxt;
  logic [IDX_W-1:0]         cur_node_r, cur_node_nxt;
  node_t                    cur_entry_r, cur_entry_nxt;
  node_t                    root_r, root_nxt;
  logic                     halted_r, halted_nxt;
  logic                     held_v_r, held_v_nxt;
  res_t                     held_r, held_nxt;

  logic             leaf_hit;
  node_t            eff;
  logic [IDX_W-1:0] eff_idx;
  logic             has_bit;
  logic             bit_val;
  logic [IDX_W-1:0] child;
  logic             present;
  logic             miss;
  logic             new_res;
  logic             can_go;
  logic             walk_done;
  logic             flush_go;
  logic             idx_ok;
  logic [CNT_W-1:0] sat_cnt;
  res_t             new_val;

  // a fetched child's node is seen from the cycle after its read, and is resolved once the walk can go
  assign leaf_hit  = pend_r & mem_rdata.leaf;
  assign eff       = pend_r ? (mem_rdata.leaf ? root_r : mem_rdata) : cur_entry_r;
  assign eff_idx   = pend_r ? (mem_rdata.leaf ? '0 : pend_idx_r) : cur_node_r;
  assign has_bit   = (cnt_r != '0);
  assign bit_val   = bits_r[0];
  assign child     = bit_val ? eff.right : eff.left;
  assign present   = bit_val ? eff.rp : eff.lp;
  assign miss      = has_bit & (~present | (32'(child) >= NODE_COUNT));
  assign new_res   = leaf_hit | miss;
  assign can_go    = ~new_res | ~held_v_r | push_ready;
  // a leaf and a miss in one cycle: emit the leaf now, take the bit later from the root
  assign walk_done = can_go & ((miss & ~leaf_hit) | ~has_bit);
  assign flush_go  = ~held_v_r | push_ready;
  assign idx_ok    = (32'(item.node_index) < NODE_COUNT);
  assign sat_cnt   = (item.valid_bits > CNT_W'(BITS_PER_BYTE)) ?
                     CNT_W'(BITS_PER_BYTE) : item.valid_bits;
  assign new_val   = leaf_hit ? res_t'{err: 1'b0, sym: mem_rdata.sym} :
                                res_t'{err: 1'b1, sym: '0};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (item_valid && item.command == CMD_DECODE) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (flush_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    bits_nxt      = bits_r;
    cnt_nxt       = cnt_r;
    eos_nxt       = eos_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    cur_node_nxt  = cur_node_r;
    cur_entry_nxt = cur_entry_r;
    root_nxt      = root_r;
    halted_nxt    = halted_r;
    held_v_nxt    = held_v_r;
    held_nxt      = held_r;
    item_ready    = (state_r == ST_IDLE);
    mem_we        = 1'b0;
    mem_waddr     = AW'(item.node_index);
    mem_wdata     = item.node;
    mem_re        = 1'b0;
    mem_raddr     = AW'(child);
    push          = '0;
    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          if (item.command == CMD_LOAD) begin
            if (idx_ok) begin
              mem_we = 1'b1;
              if (item.node_index == '0) begin
                root_nxt = item.node;
              end
              if (item.node_index == cur_node_r) begin
                cur_entry_nxt = item.node;
              end
            end
            if (item.eos) begin
              cur_node_nxt  = '0;
              cur_entry_nxt = root_nxt;
              halted_nxt    = 1'b0;
            end
          end else begin
            bits_nxt = item.data_byte;
            cnt_nxt  = halted_r ? '0 : sat_cnt;
            eos_nxt  = item.eos;
          end
        end
      end
      ST_WALK: begin
        if (can_go) begin
          if (new_res) begin
            // a held result goes out, not last, once the next one shows up; else the flush marks it last
            push.valid = held_v_r;
            push.last  = 1'b0;
            push.res   = held_r;
            held_v_nxt = 1'b1;
            held_nxt   = new_val;
          end
          cur_entry_nxt = eff;
          cur_node_nxt  = eff_idx;
          pend_nxt      = 1'b0;
          if (!(leaf_hit && miss)) begin
            if (miss) begin
              halted_nxt = 1'b1;
            end else if (has_bit) begin
              mem_re       = 1'b1;
              pend_nxt     = 1'b1;
              pend_idx_nxt = child;
              bits_nxt     = bits_r >> 1;
              cnt_nxt      = cnt_r - 1'b1;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (flush_go) begin
          push.valid = held_v_r;
          push.last  = 1'b1;
          push.res   = held_r;
          held_v_nxt = 1'b0;
          cnt_nxt    = '0;
          if (eos_r) begin
            cur_node_nxt  = '0;
            cur_entry_nxt = root_r;
            halted_nxt    = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      pend_r     <= 1'b0;
      cur_node_r <= '0;
      halted_r   <= 1'b0;
      held_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      pend_r     <= pend_nxt;
      cur_node_r <= cur_node_nxt;
      halted_r   <= halted_nxt;
      held_v_r   <= held_v_nxt;
    end
    bits_r      <= bits_nxt;
    eos_r       <= eos_nxt;
    pend_idx_r  <= pend_idx_nxt;
    cur_entry_r <= cur_entry_nxt;
    root_r      <= root_nxt;
    held_r      <= held_nxt;
  end

  a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == ST_WALK)
    else $error("child fetch pending outside the walk");

  a_idle_nothing_held: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !held_v_r && !pend_r)
    else $error("result or fetch left over in idle");

  a_halt_has_error: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(halted_r) |-> held_v_r && held_r.err)
    else $error("halt raised without an error result");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(BITS_PER_BYTE))
    else $error("bit count beyond a byte");

  a_push_only_ready: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> push_ready)
    else $error("result pushed into a full output stage");

endmodule
`default_nettype wire

/* rtl/huffman_tree_walk_decoder.sv */
// load transfer: the node is written at the accepting edge
// decode transfer: the valid bits (max 8) are taken from bit 0 up, with at most
//   one node table read per bit; a symbol leaves once the next result or the item end
//   shows it is or is not the last one, through one output register
// halted walk or zero bits: no node table read in a decode transfer
// reset (rst_n low, synchronous): walk at root node 0, halt cleared, no result pending;
//   the node table is not cleared and holds garbage until loaded
`default_nettype none
module huffman_tree_walk_decoder import htwd_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // node_index[8:0], left_child[17:9], right_child[26:18], left_present[27],
  // right_present[28], leaf_flag[29], leaf_symbol[37:30], data_byte[45:38],
  // valid_bits[49:46], zero[55:50]
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  in_tuser,   // command
  input  wire logic                  in_tlast,   // end_of_stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [SYM_W-1:0]           out_tdata,  // symbol[7:0]
  output logic                       out_tuser,  // decode_error
  output logic                       out_tlast   // last
);

  localparam int AW = $clog2(NODE_COUNT);

  item_t            item;
  push_t            push;
  logic             push_ready;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  node_t            mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  node_t            mem_rdata;

  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r, out_res_nxt;
  logic             out_last_r, out_last_nxt;

  always_comb begin
    item.command    = cmd_t'(in_tuser);
    item.node_index = in_tdata[8:0];
    item.node.left  = in_tdata[17:9];
    item.node.right = in_tdata[26:18];
    item.node.lp    = in_tdata[27];
    item.node.rp    = in_tdata[28];
    item.node.leaf  = in_tdata[29];
    item.node.sym   = in_tdata[37:30];
    item.data_byte  = in_tdata[45:38];
    item.valid_bits = in_tdata[49:46];
    item.eos        = in_tlast;
  end

  htwd_node_mem #(
    .NODE_COUNT (NODE_COUNT),
    .AW         (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  htwd_walker #(
    .NODE_COUNT (NODE_COUNT),
    .AW         (AW)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .push       (push),
    .push_ready (push_ready),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // output register takes a new result when empty or draining this cycle
  assign push_ready = ~out_valid_r | out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    if (push.valid && push_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = push.res;
      out_last_nxt  = push.last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.sym;
  assign out_tuser  = out_res_r.err;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

/* test/huffman_tree_walk_decoder_tb.sv */
`timescale 1ns / 1ps
module huffman_tree_walk_decoder_tb;
  import htwd_pkg::*;

  localparam int TOTAL_ITEMS  = 350;
  localparam int PHASE1_AT    = 150;
  localparam int PHASE2_AT    = 270;
  localparam int HOLD_AT      = 290;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             err;
    logic             last;
  } sym_result_t;

  // tracks the code tree and the walk, queues the symbols each decode should give
  class symbol_scoreboard;
    node_t            nodes [NODE_COUNT_DEF];
    bit               loaded [NODE_COUNT_DEF];
    logic [IDX_W-1:0] walk_node;
    bit               halted;
    sym_result_t      pending_symbols [$];
    int               mismatches;

    function new();
      walk_node  = '0;
      halted     = 0;
      mismatches = 0;
      foreach (nodes[i]) begin
        nodes[i]  = '0;
        loaded[i] = 0;
      end
    endfunction

    // number of leading bits of data that the walk can take without touching an unloaded slot
    function int safe_bits(logic [7:0] data);
      logic [IDX_W-1:0] at;
      node_t            n;
      logic [IDX_W-1:0] child;
      logic             present;
      at = walk_node;
      if (halted) return BITS_PER_BYTE;
      for (int b = 0; b < BITS_PER_BYTE; b++) begin
        if (!loaded[at]) return b;
        n       = nodes[at];
        child   = data[b] ? n.right : n.left;
        present = data[b] ? n.rp : n.lp;
        if (!present || child >= NODE_COUNT_DEF) return BITS_PER_BYTE;
        if (!loaded[child]) return b;
        at = nodes[child].leaf ? '0 : child;
      end
      return BITS_PER_BYTE;
    endfunction

    function void note_item(item_t it);
      sym_result_t      held;
      sym_result_t      r;
      bit               have_held;
      bit               stop;
      bit               emit;
      int               nb;
      node_t            n;
      logic [IDX_W-1:0] child;
      logic             present;
      have_held = 0;
      stop      = 0;
      held      = '0;
      r         = '0;
      if (it.command == CMD_LOAD) begin
        if (it.node_index < NODE_COUNT_DEF) begin
          nodes[it.node_index]  = it.node;
          loaded[it.node_index] = 1;
        end
      end else if (!halted) begin
        nb = (it.valid_bits > BITS_PER_BYTE) ? BITS_PER_BYTE : int'(it.valid_bits);
        for (int b = 0; b < nb && !stop; b++) begin
          emit    = 0;
          n       = nodes[walk_node];
          child   = it.data_byte[b] ? n.right : n.left;
          present = it.data_byte[b] ? n.rp : n.lp;
          if (!present || child >= NODE_COUNT_DEF) begin
            r      = '{sym: '0, err: 1'b1, last: 1'b0};
            halted = 1;
            stop   = 1;
            emit   = 1;
          end else if (nodes[child].leaf) begin
            r         = '{sym: nodes[child].sym, err: 1'b0, last: 1'b0};
            walk_node = '0;
            emit      = 1;
          end else begin
            walk_node = child;
          end
          if (emit) begin
            if (have_held) pending_symbols.push_back(held);
            held      = r;
            have_held = 1;
          end
        end
      end
      // the final symbol of the item carries last
      if (have_held) begin
        held.last = 1'b1;
        pending_symbols.push_back(held);
      end
      if (it.eos) begin
        walk_node = '0;
        halted    = 0;
      end
    endfunction

    task report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_symbol(logic [SYM_W-1:0] sym, logic err, logic last);
      sym_result_t want;
      if (pending_symbols.size() == 0) begin
        report($sformatf("unexpected result sym %02h err %0b last %0b", sym, err, last));
      end else begin
        want = pending_symbols.pop_front();
        if (sym !== want.sym) report($sformatf("symbol %02h, expected %02h", sym, want.sym));
        if (err !== want.err) report($sformatf("decode_error %0b, expected %0b", err, want.err));
        if (last !== want.last) report($sformatf("last %0b, expected %0b", last, want.last));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [SYM_W-1:0]      out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  symbol_scoreboard sb;
  int items_sent   = 0;
  int in_idle_pct  = 24;
  int out_idle_pct = 68;
  int cycle_count  = 0;
  bit rx_hold      = 1'b0;

  huffman_tree_walk_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL huffman_tree_walk_decoder");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_symbol(out_tdata, out_tuser, out_tlast);
    out_tready <= !rx_hold && ($urandom_range(99) >= out_idle_pct);
  end

  // long receiver stall once the sender runs without gaps, so the input backs up
  initial begin
    wait (items_sent >= HOLD_AT);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic node_t make_node(logic [IDX_W-1:0] left, logic [IDX_W-1:0] right,
                                      logic lp, logic rp, logic leaf, logic [SYM_W-1:0] sym);
    node_t n;
    n = '{sym: sym, leaf: leaf, rp: rp, lp: lp, right: right, left: left};
    return n;
  endfunction

  task automatic send_item(item_t it);
    if (items_sent < PHASE1_AT) begin
      in_idle_pct = 24;
      out_idle_pct <= 68;
    end else if (items_sent < PHASE2_AT) begin
      in_idle_pct = 68;
      out_idle_pct <= 24;
    end else begin
      in_idle_pct = 0;
      out_idle_pct <= 0;
    end
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.command;
    in_tlast  <= it.eos;
    in_tdata  <= {6'b0, it.valid_bits, it.data_byte, it.node, it.node_index};
    do @(posedge clk); while (!in_tready);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic load_node(logic [IDX_W-1:0] idx, node_t n, logic eos);
    item_t it;
    it.command    = CMD_LOAD;
    it.node_index = idx;
    it.node       = n;
    it.data_byte  = 8'($urandom);
    it.valid_bits = 4'($urandom);
    it.eos        = eos;
    send_item(it);
  endtask

  task automatic decode_byte(logic [7:0] data, logic [CNT_W-1:0] vb, logic eos);
    item_t it;
    int    reach;
    int    eff;
    // never let the walk read a slot that was not loaded
    reach = sb.safe_bits(data);
    eff   = (vb > BITS_PER_BYTE) ? BITS_PER_BYTE : int'(vb);
    if (eff > reach) vb = 4'(reach);
    it.command    = CMD_DECODE;
    it.node_index = 9'($urandom);
    it.node       = 29'($urandom);
    it.data_byte  = data;
    it.valid_bits = vb;
    it.eos        = eos;
    send_item(it);
  endtask

  // random full tree rooted at 0, loaded in random order, then a burst of bytes
  task automatic tree_episode();
    logic [IDX_W-1:0] ids [17];
    bit               is_leaf [17];
    int               lc [17];
    int               rc [17];
    int               order [$];
    int               cnt;
    int               leaves;
    int               want_leaves;
    int               p;
    int               j;
    int               nd;
    logic [IDX_W-1:0] cand;
    logic [CNT_W-1:0] vb;
    bit               clash;
    node_t            n;
    cnt         = 1;
    leaves      = 1;
    ids[0]      = '0;
    is_leaf[0]  = 1;
    want_leaves = $urandom_range(9, 2);
    while (leaves < want_leaves) begin
      do p = $urandom_range(cnt - 1); while (!is_leaf[p]);
      for (int c = 0; c < 2; c++) begin
        do begin
          cand  = 9'($urandom_range(NODE_COUNT_DEF - 1, 1));
          clash = 0;
          for (int k = 0; k < cnt + c; k++) if (ids[k] == cand) clash = 1;
        end while (clash);
        ids[cnt + c]     = cand;
        is_leaf[cnt + c] = 1;
      end
      is_leaf[p] = 0;
      lc[p]      = cnt;
      rc[p]      = cnt + 1;
      cnt       += 2;
      leaves++;
    end
    for (int i = 0; i < cnt; i++) order.push_back(i);
    while (order.size() > 0) begin
      j = $urandom_range(order.size() - 1);
      p = order[j];
      order.delete(j);
      if (is_leaf[p]) begin
        n      = 29'($urandom);
        n.leaf = 1'b1;
      end else begin
        // the root's own leaf flag is never looked at
        n = make_node(ids[lc[p]], ids[rc[p]], 1'b1, 1'b1,
                      (p == 0) ? 1'($urandom) : 1'b0, 8'($urandom));
        if ($urandom_range(9) == 0) begin
          if ($urandom_range(1) == 1) n.lp = 1'b0;
          else n.rp = 1'b0;
        end
      end
      load_node(ids[p], n, $urandom_range(15) == 0);
      if ($urandom_range(11) == 0) load_node(9'($urandom), 29'($urandom), 1'b0);
    end
    nd = $urandom_range(10, 3);
    for (int i = 0; i < nd; i++) begin
      vb = ($urandom_range(9) < 7) ? 4'd8 : 4'($urandom);
      decode_byte(8'($urandom), vb, (i == nd - 1) || ($urandom_range(11) == 0));
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // root with a leaf flag set, two leaves at the extreme slots
    load_node(9'd0, make_node(9'd1, 9'd511, 1'b1, 1'b1, 1'b1, 8'hAA), 1'b0);
    load_node(9'd1, make_node(9'd0, 9'd0, 1'b0, 1'b0, 1'b1, 8'h00), 1'b0);
    load_node(9'd511, make_node(9'd511, 9'd511, 1'b1, 1'b1, 1'b1, 8'hFF), 1'b0);
    decode_byte(8'h00, 4'd8, 1'b0);
    decode_byte(8'hFF, 4'd15, 1'b0);
    decode_byte(8'h5A, 4'd0, 1'b0);
    decode_byte(8'hA5, 4'd9, 1'b0);
    // inner node whose right link is missing
    load_node(9'd2, make_node(9'd3, 9'd0, 1'b1, 1'b0, 1'b0, 8'h55), 1'b0);
    load_node(9'd3, make_node(9'd0, 9'd0, 1'b0, 1'b0, 1'b1, 8'h3C), 1'b0);
    load_node(9'd0, make_node(9'd1, 9'd2, 1'b1, 1'b1, 1'b0, 8'h00), 1'b0);
    decode_byte(8'h02, 4'd3, 1'b0);
    decode_byte(8'h01, 4'd1, 1'b0);
    // end of stream on a load drops the partial walk
    load_node(9'd3, make_node(9'd0, 9'd0, 1'b0, 1'b0, 1'b1, 8'h3C), 1'b1);
    decode_byte(8'h03, 4'd4, 1'b0);
    decode_byte(8'h00, 4'd8, 1'b0);
    decode_byte(8'h00, 4'd8, 1'b1);
    decode_byte(8'h00, 4'd2, 1'b0);
    decode_byte(8'h07, 4'd8, 1'b1);
    decode_byte(8'h06, 4'd5, 1'b0);
    decode_byte(8'h01, 4'd8, 1'b1);
    load_node(9'd2, make_node(9'd3, 9'd511, 1'b1, 1'b1, 1'b0, 8'h55), 1'b0);
    decode_byte(8'hF5, 4'd8, 1'b0);
    decode_byte(8'h01, 4'd1, 1'b1);

    while (items_sent < TOTAL_ITEMS) tree_episode();
    in_tvalid <= 1'b0;

    while (sb.pending_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS huffman_tree_walk_decoder");
    end else begin
      $display("FAIL huffman_tree_walk_decoder");
    end
    $finish;
  end

endmodule
